// File: design/fuzzy_pd_motor_velocity_unit_defines.svh
// Assertion macros shared by the fuzzy PD motor velocity unit.
`ifndef FUZZY_PD_MOTOR_VELOCITY_UNIT_DEFINES_SVH
`define FUZZY_PD_MOTOR_VELOCITY_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Clocked by i_clk and held off while i_rst_n is low.
`define FPDMV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Clocked by i_clk and checked during reset as well.
`define FPDMV_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);
`else
`define FPDMV_ASSERT(label, prop, msg)
`define FPDMV_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// File: design/fpdmv_pkg.sv
// Shared constants, types and register indexes of the fuzzy PD motor velocity unit.
`default_nettype none
package fpdmv_pkg;

    localparam int FIELD_W   = 16;
    localparam int GAIN_W    = 8;
    localparam int DUTY_W    = 8;
    localparam int NUM_GAINS = 6;
    localparam int CFG_IDX_W = $clog2(NUM_GAINS);
    localparam int MEMB_W    = 4;
    localparam int DEN_W     = 5;
    localparam int NUM_W     = 13;
    localparam int MAG_W     = FIELD_W + 1;
    localparam int PROD_W    = MAG_W + NUM_W;
    localparam int DIV_W     = 28;
    localparam int QUO_W     = DIV_W + 1;
    localparam int CNT_W     = $clog2(DIV_W);
    localparam int SUM_W     = 31;
    localparam int VEL_W     = 9;

    // Membership classes.
    localparam int M_NEG  = 0;
    localparam int M_ZERO = 1;
    localparam int M_POS  = 2;

    localparam logic [MEMB_W-1:0]         MEMB_FULL = MEMB_W'(10);
    localparam logic signed [FIELD_W-1:0] IN_FULL   = FIELD_W'(10);
    localparam logic signed [SUM_W-1:0]   VEL_HI    = SUM_W'(255);
    localparam logic signed [SUM_W-1:0]   VEL_LO    = SUM_W'(-255);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_KP_SMALL  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_KP_MEDIUM = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_KP_LARGE  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_KD_SMALL  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_KD_MEDIUM = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_KD_LARGE  = CFG_IDX_W'(5);

    typedef logic [2:0][MEMB_W-1:0] t_memb;

    typedef struct packed {
        logic [GAIN_W-1:0] kp_lo;
        logic [GAIN_W-1:0] kp_mid;
        logic [GAIN_W-1:0] kp_hi;
        logic [GAIN_W-1:0] kd_lo;
        logic [GAIN_W-1:0] kd_mid;
        logic [GAIN_W-1:0] kd_hi;
    } t_gain_set;

    typedef struct packed {
        logic start;
        logic ack;
    } t_lane_ctrl;

    typedef struct packed {
        logic                    done;
        logic signed [VEL_W-1:0] vel_next;
    } t_lane_stat;

    typedef enum logic [2:0] {
        L_IDLE,
        L_WGT,
        L_NUM,
        L_MUL,
        L_START,
        L_DIV,
        L_DONE
    } t_lane_state;

endpackage
`default_nettype wire

// File: design/fpdmv_div.sv
// Serial restoring divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module fpdmv_div (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_start,
    input  wire logic [fpdmv_pkg::DIV_W-1:0]            i_dividend,
    input  wire logic                                   i_neg,
    input  wire logic [fpdmv_pkg::DEN_W-1:0]            i_divisor,
    output logic                                        o_done,
    output logic signed [fpdmv_pkg::QUO_W-1:0]          o_quot
);

    logic                          r_run;
    logic                          r_done;
    logic [fpdmv_pkg::CNT_W-1:0]   r_cnt;
    logic [fpdmv_pkg::DIV_W-1:0]   r_quo;
    logic [fpdmv_pkg::DEN_W-1:0]   r_rem;
    logic [fpdmv_pkg::DEN_W-1:0]   r_den;
    logic                          r_neg;

    logic [fpdmv_pkg::DEN_W:0]     trial;
    logic                          fits;
    logic [fpdmv_pkg::DEN_W-1:0]   n_rem;
    logic [fpdmv_pkg::QUO_W-1:0]   quo_ext;

    always_comb begin
        trial = {r_rem, r_quo[fpdmv_pkg::DIV_W-1]};
        fits  = trial >= {1'b0, r_den};
        // The remainder stays below the divisor, so the difference fits back in DEN_W bits.
        if (fits) begin
            n_rem = fpdmv_pkg::DEN_W'(trial - {1'b0, r_den});
        end else begin
            n_rem = trial[fpdmv_pkg::DEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= fpdmv_pkg::CNT_W'(fpdmv_pkg::DIV_W - 1);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
            r_neg <= i_neg;
        end else if (r_run) begin
            r_quo <= {r_quo[fpdmv_pkg::DIV_W-2:0], fits};
            r_rem <= n_rem;
        end
    end

    assign quo_ext = {1'b0, r_quo};
    assign o_quot  = r_neg ? -$signed(quo_ext) : $signed(quo_ext);
    assign o_done  = r_done;

endmodule
`default_nettype wire

// File: design/fpdmv_lane.sv
// One motor lane: fuzzy gain scheduling, correction by two serial dividers, velocity update.
`default_nettype none
module fpdmv_lane (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire fpdmv_pkg::t_lane_ctrl                 i_ctrl,
    input  wire logic signed [fpdmv_pkg::FIELD_W-1:0]  i_error,
    input  wire logic signed [fpdmv_pkg::FIELD_W-1:0]  i_error_rate,
    input  wire fpdmv_pkg::t_gain_set                  i_gains,
    output fpdmv_pkg::t_lane_stat                      o_stat
);

    function automatic fpdmv_pkg::t_memb fuzzify(input logic signed [fpdmv_pkg::FIELD_W-1:0] x);
        fpdmv_pkg::t_memb                   m;
        logic signed [fpdmv_pkg::FIELD_W-1:0] neg;
        m   = '0;
        neg = -x;
        if (x > fpdmv_pkg::IN_FULL) begin
            m[fpdmv_pkg::M_POS] = fpdmv_pkg::MEMB_FULL;
        end else if (x < -fpdmv_pkg::IN_FULL) begin
            m[fpdmv_pkg::M_NEG] = fpdmv_pkg::MEMB_FULL;
        end else if (x > 0) begin
            m[fpdmv_pkg::M_POS]  = x[fpdmv_pkg::MEMB_W-1:0];
            m[fpdmv_pkg::M_ZERO] = fpdmv_pkg::MEMB_FULL - x[fpdmv_pkg::MEMB_W-1:0];
        end else begin
            m[fpdmv_pkg::M_NEG]  = neg[fpdmv_pkg::MEMB_W-1:0];
            m[fpdmv_pkg::M_ZERO] = fpdmv_pkg::MEMB_FULL - neg[fpdmv_pkg::MEMB_W-1:0];
        end
        return m;
    endfunction

    function automatic logic [fpdmv_pkg::MEMB_W-1:0] mn(input logic [fpdmv_pkg::MEMB_W-1:0] a,
                                                       input logic [fpdmv_pkg::MEMB_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [fpdmv_pkg::MEMB_W-1:0] mx(input logic [fpdmv_pkg::MEMB_W-1:0] a,
                                                       input logic [fpdmv_pkg::MEMB_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    fpdmv_pkg::t_lane_state r_state;
    fpdmv_pkg::t_lane_state n_state;

    logic signed [fpdmv_pkg::FIELD_W-1:0] r_e;
    logic signed [fpdmv_pkg::FIELD_W-1:0] r_de;
    logic [fpdmv_pkg::MEMB_W-1:0]  r_ps, r_pm, r_pl, r_ds, r_dm, r_dl;
    logic [fpdmv_pkg::NUM_W-1:0]   r_pnum, r_dnum;
    logic [fpdmv_pkg::DEN_W-1:0]   r_pden, r_dden;
    logic [fpdmv_pkg::DIV_W-1:0]   r_pmag, r_dmag;
    logic                          r_pneg, r_dneg;
    logic signed [fpdmv_pkg::VEL_W-1:0] r_vel;

    fpdmv_pkg::t_memb               me, md;
    logic [2:0][2:0][fpdmv_pkg::MEMB_W-1:0] rl;
    logic [fpdmv_pkg::MEMB_W-1:0]   ps, pm, pl, ds, dm, dl;

    logic signed [fpdmv_pkg::MAG_W-1:0] e_ext, de_ext;
    logic [fpdmv_pkg::MAG_W-1:0]    e_abs, de_abs;
    logic [fpdmv_pkg::PROD_W-1:0]   p_prod, d_prod;

    logic                           div_start;
    logic                           p_done, d_done;
    logic signed [fpdmv_pkg::QUO_W-1:0] p_quot, d_quot;
    logic signed [fpdmv_pkg::SUM_W-1:0] sum;
    logic signed [fpdmv_pkg::VEL_W-1:0] n_vel;

    // Rule matrix: row is the error class, column the error-rate class.
    always_comb begin
        me = fuzzify(r_e);
        md = fuzzify(r_de);
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                rl[i][j] = mn(md[j], me[i]);
            end
        end
        ps = rl[1][1];
        pm = mx(mx(mx(rl[1][0], rl[0][1]), mx(rl[2][1], rl[1][2])), mx(rl[0][0], rl[2][2]));
        pl = mx(rl[0][2], rl[2][0]);
        ds = mx(mx(rl[0][2], rl[2][0]), rl[1][1]);
        dm = mx(mx(rl[0][0], rl[0][1]), mx(rl[2][1], rl[2][2]));
        dl = mx(rl[1][0], rl[1][2]);
    end

    always_comb begin
        e_ext  = {r_e[fpdmv_pkg::FIELD_W-1], r_e};
        de_ext = {r_de[fpdmv_pkg::FIELD_W-1], r_de};
        e_abs  = r_e[fpdmv_pkg::FIELD_W-1] ? fpdmv_pkg::MAG_W'(-e_ext) : fpdmv_pkg::MAG_W'(e_ext);
        de_abs = r_de[fpdmv_pkg::FIELD_W-1] ? fpdmv_pkg::MAG_W'(-de_ext)
                                            : fpdmv_pkg::MAG_W'(de_ext);
        p_prod = fpdmv_pkg::PROD_W'(e_abs) * fpdmv_pkg::PROD_W'(r_pnum);
        d_prod = fpdmv_pkg::PROD_W'(de_abs) * fpdmv_pkg::PROD_W'(r_dnum);
    end

    always_comb begin
        sum = fpdmv_pkg::SUM_W'(r_vel) + fpdmv_pkg::SUM_W'(p_quot) + fpdmv_pkg::SUM_W'(d_quot);
        priority if (sum > fpdmv_pkg::VEL_HI) begin
            n_vel = fpdmv_pkg::VEL_W'(fpdmv_pkg::VEL_HI);
        end else if (sum < fpdmv_pkg::VEL_LO) begin
            n_vel = fpdmv_pkg::VEL_W'(fpdmv_pkg::VEL_LO);
        end else begin
            n_vel = fpdmv_pkg::VEL_W'(sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fpdmv_pkg::L_IDLE;
            r_vel   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == fpdmv_pkg::L_DONE && i_ctrl.ack) begin
                r_vel <= n_vel;
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        unique case (r_state)
            fpdmv_pkg::L_IDLE: begin
                if (i_ctrl.start) n_state = fpdmv_pkg::L_WGT;
            end
            fpdmv_pkg::L_WGT:  n_state = fpdmv_pkg::L_NUM;
            fpdmv_pkg::L_NUM:  n_state = fpdmv_pkg::L_MUL;
            fpdmv_pkg::L_MUL:  n_state = fpdmv_pkg::L_START;
            fpdmv_pkg::L_START: begin
                div_start = 1'b1;
                n_state   = fpdmv_pkg::L_DIV;
            end
            fpdmv_pkg::L_DIV: begin
                if (p_done && d_done) n_state = fpdmv_pkg::L_DONE;
            end
            fpdmv_pkg::L_DONE: begin
                if (i_ctrl.ack) n_state = fpdmv_pkg::L_IDLE;
            end
            default: n_state = fpdmv_pkg::L_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            fpdmv_pkg::L_IDLE: begin
                if (i_ctrl.start) begin
                    r_e  <= i_error;
                    r_de <= i_error_rate;
                end
            end
            fpdmv_pkg::L_WGT: begin
                r_ps <= ps;
                r_pm <= pm;
                r_pl <= pl;
                r_ds <= ds;
                r_dm <= dm;
                r_dl <= dl;
            end
            fpdmv_pkg::L_NUM: begin
                r_pnum <= fpdmv_pkg::NUM_W'(r_ps) * fpdmv_pkg::NUM_W'(i_gains.kp_lo)
                        + fpdmv_pkg::NUM_W'(r_pm) * fpdmv_pkg::NUM_W'(i_gains.kp_mid)
                        + fpdmv_pkg::NUM_W'(r_pl) * fpdmv_pkg::NUM_W'(i_gains.kp_hi);
                r_dnum <= fpdmv_pkg::NUM_W'(r_ds) * fpdmv_pkg::NUM_W'(i_gains.kd_lo)
                        + fpdmv_pkg::NUM_W'(r_dm) * fpdmv_pkg::NUM_W'(i_gains.kd_mid)
                        + fpdmv_pkg::NUM_W'(r_dl) * fpdmv_pkg::NUM_W'(i_gains.kd_hi);
                r_pden <= fpdmv_pkg::DEN_W'(r_ps) + fpdmv_pkg::DEN_W'(r_pm)
                        + fpdmv_pkg::DEN_W'(r_pl);
                r_dden <= fpdmv_pkg::DEN_W'(r_ds) + fpdmv_pkg::DEN_W'(r_dm)
                        + fpdmv_pkg::DEN_W'(r_dl);
            end
            fpdmv_pkg::L_MUL: begin
                // The magnitude is bounded by 32768 * 7650, which fits in DIV_W bits.
                r_pmag <= p_prod[fpdmv_pkg::DIV_W-1:0];
                r_dmag <= d_prod[fpdmv_pkg::DIV_W-1:0];
                r_pneg <= r_e[fpdmv_pkg::FIELD_W-1];
                r_dneg <= r_de[fpdmv_pkg::FIELD_W-1];
            end
            default: begin
            end
        endcase
    end

    fpdmv_div u_div_p (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_pmag),
        .i_neg      (r_pneg),
        .i_divisor  (r_pden),
        .o_done     (p_done),
        .o_quot     (p_quot)
    );

    fpdmv_div u_div_d (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_dmag),
        .i_neg      (r_dneg),
        .i_divisor  (r_dden),
        .o_done     (d_done),
        .o_quot     (d_quot)
    );

    assign o_stat.done     = (r_state == fpdmv_pkg::L_DONE);
    assign o_stat.vel_next = n_vel;

`include "fuzzy_pd_motor_velocity_unit_defines.svh"

    `FPDMV_ASSERT(a_div_pair_done, p_done == d_done, "lane dividers finished apart")
    `FPDMV_ASSERT(a_done_in_div, p_done |-> (r_state == fpdmv_pkg::L_DIV), "done outside wait")
    `FPDMV_ASSERT(a_vel_range, (r_vel <= 9'sd255) && (r_vel >= -9'sd255), "velocity out of range")

endmodule
`default_nettype wire

// File: design/fuzzy_pd_motor_velocity_unit.sv
// Top level of the two-lane fuzzy self-tuning PD motor velocity unit.
// Each input transaction carries an error and an error rate for motors A and B; both lanes
// schedule their gains from six configured values, update their velocity and the merged
// result leaves as a reverse/forward duty pair per motor. One transaction is in flight at a time;
// each lane computes its correction with two 28-step serial dividers, and the next transaction
// is accepted once the result enters the output register, which waits while the output side
// still holds an earlier result.
`default_nettype none
module fuzzy_pd_motor_velocity_unit (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_cfg_we,
    input  wire logic [fpdmv_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [fpdmv_pkg::GAIN_W-1:0]           i_cfg_data,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_ready,
    input  wire logic signed [fpdmv_pkg::FIELD_W-1:0]   i_error_a,
    input  wire logic signed [fpdmv_pkg::FIELD_W-1:0]   i_error_rate_a,
    input  wire logic signed [fpdmv_pkg::FIELD_W-1:0]   i_error_b,
    input  wire logic signed [fpdmv_pkg::FIELD_W-1:0]   i_error_rate_b,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_ready,
    output logic [fpdmv_pkg::DUTY_W-1:0]                o_reverse_duty_a,
    output logic [fpdmv_pkg::DUTY_W-1:0]                o_forward_duty_a,
    output logic [fpdmv_pkg::DUTY_W-1:0]                o_forward_duty_b,
    output logic [fpdmv_pkg::DUTY_W-1:0]                o_reverse_duty_b
);

    logic [fpdmv_pkg::GAIN_W-1:0] r_gain [fpdmv_pkg::NUM_GAINS];
    logic                         r_busy;
    logic                         r_out_valid;
    logic [fpdmv_pkg::DUTY_W-1:0] r_rev_a, r_fwd_a, r_fwd_b, r_rev_b;

    fpdmv_pkg::t_gain_set  gains;
    fpdmv_pkg::t_lane_ctrl ctrl;
    fpdmv_pkg::t_lane_stat stat_a, stat_b;
    logic                  in_acc;
    logic                  ack;
    logic signed [fpdmv_pkg::VEL_W-1:0] neg_a, neg_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < fpdmv_pkg::NUM_GAINS; i++) begin
                r_gain[i] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fpdmv_pkg::REG_KP_SMALL:  r_gain[fpdmv_pkg::REG_KP_SMALL]  <= i_cfg_data;
                fpdmv_pkg::REG_KP_MEDIUM: r_gain[fpdmv_pkg::REG_KP_MEDIUM] <= i_cfg_data;
                fpdmv_pkg::REG_KP_LARGE:  r_gain[fpdmv_pkg::REG_KP_LARGE]  <= i_cfg_data;
                fpdmv_pkg::REG_KD_SMALL:  r_gain[fpdmv_pkg::REG_KD_SMALL]  <= i_cfg_data;
                fpdmv_pkg::REG_KD_MEDIUM: r_gain[fpdmv_pkg::REG_KD_MEDIUM] <= i_cfg_data;
                fpdmv_pkg::REG_KD_LARGE:  r_gain[fpdmv_pkg::REG_KD_LARGE]  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        gains.kp_lo  = r_gain[fpdmv_pkg::REG_KP_SMALL];
        gains.kp_mid = r_gain[fpdmv_pkg::REG_KP_MEDIUM];
        gains.kp_hi  = r_gain[fpdmv_pkg::REG_KP_LARGE];
        gains.kd_lo  = r_gain[fpdmv_pkg::REG_KD_SMALL];
        gains.kd_mid = r_gain[fpdmv_pkg::REG_KD_MEDIUM];
        gains.kd_hi  = r_gain[fpdmv_pkg::REG_KD_LARGE];
    end

    assign o_in_ready = !r_busy;
    assign in_acc     = i_in_valid && !r_busy;
    // The lanes finish together; the merge waits for a free output register.
    assign ack        = stat_a.done && stat_b.done && (!r_out_valid || i_out_ready);
    assign ctrl.start = in_acc;
    assign ctrl.ack   = ack;

    fpdmv_lane u_lane_a (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl),
        .i_error      (i_error_a),
        .i_error_rate (i_error_rate_a),
        .i_gains      (gains),
        .o_stat       (stat_a)
    );

    fpdmv_lane u_lane_b (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl),
        .i_error      (i_error_b),
        .i_error_rate (i_error_rate_b),
        .i_gains      (gains),
        .o_stat       (stat_b)
    );

    assign neg_a = -stat_a.vel_next;
    assign neg_b = -stat_b.vel_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_busy <= 1'b1;
            end else if (ack) begin
                r_busy <= 1'b0;
            end
            if (ack) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ack) begin
            if (stat_a.vel_next[fpdmv_pkg::VEL_W-1]) begin
                r_rev_a <= neg_a[fpdmv_pkg::DUTY_W-1:0];
                r_fwd_a <= '0;
            end else begin
                r_rev_a <= '0;
                r_fwd_a <= stat_a.vel_next[fpdmv_pkg::DUTY_W-1:0];
            end
            if (stat_b.vel_next[fpdmv_pkg::VEL_W-1]) begin
                r_rev_b <= neg_b[fpdmv_pkg::DUTY_W-1:0];
                r_fwd_b <= '0;
            end else begin
                r_rev_b <= '0;
                r_fwd_b <= stat_b.vel_next[fpdmv_pkg::DUTY_W-1:0];
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_reverse_duty_a = r_rev_a;
    assign o_forward_duty_a = r_fwd_a;
    assign o_forward_duty_b = r_fwd_b;
    assign o_reverse_duty_b = r_rev_b;

`include "fuzzy_pd_motor_velocity_unit_defines.svh"

    `FPDMV_ASSERT(a_lanes_lockstep, stat_a.done == stat_b.done, "lanes out of step")
    `FPDMV_ASSERT(a_ack_when_busy, ack |-> r_busy, "result merged with no transaction in flight")
    `FPDMV_ASSERT(a_accept_blocks, in_acc |=> !o_in_ready, "input taken while lanes were busy")
    `FPDMV_ASSERT(a_dir_a, o_out_valid |-> (r_rev_a == '0 || r_fwd_a == '0), "motor A both ways")
    `FPDMV_ASSERT(a_dir_b, o_out_valid |-> (r_rev_b == '0 || r_fwd_b == '0), "motor B both ways")

endmodule
`default_nettype wire
